// ===== src/rbl_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the RGB
// brightness limiter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rbl_pkg;

  localparam int DIV_STEPS_A = 6;
  localparam int DIV_STEPS_B = 5;
  localparam int DIV_STEPS_C = 5;

  localparam logic [18:0] H_TURN = 19'd393216;  // six sectors
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // configuration register indexes
  localparam logic REG_MAX_LEVEL     = 1'b0;
  localparam logic REG_CHANNEL_ORDER = 1'b1;

  // LED channel orders
  localparam logic [2:0] ORD_RGB = 3'd0;
  localparam logic [2:0] ORD_RBG = 3'd1;
  localparam logic [2:0] ORD_GBR = 3'd2;
  localparam logic [2:0] ORD_GRB = 3'd3;
  localparam logic [2:0] ORD_BRG = 3'd4;
  localparam logic [2:0] ORD_BGR = 3'd5;

  // Payload through the two dividers: hue fraction and saturation.
  typedef struct packed {
    logic [7:0]  rem_h;
    logic [16:0] q_h;
    logic [7:0]  rem_s;
    logic [16:0] q_s;
    logic [7:0]  den_h;
    logic [7:0]  den_s;
    logic [2:0]  base;
    logic        neg;
    logic        grey;
    logic [16:0] v;
  } div_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [16:0] q;
  } step_t;

  // One restoring division step; remainder stays below the divisor.
  function automatic step_t div_step(input logic [7:0] rem, input logic [16:0] q,
                                     input logic [7:0] den);
    logic [8:0] r9;
    step_t      res;
    r9 = {rem, 1'b0};
    if (r9 >= {1'b0, den}) begin
      r9    = r9 - {1'b0, den};
      res.q = {q[15:0], 1'b1};
    end else begin
      res.q = {q[15:0], 1'b0};
    end
    res.rem = r9[7:0];
    return res;
  endfunction

  // (x * 255) >> 16 for x up to 1.0 in Q0.16
  function automatic logic [7:0] scale_byte(input logic [16:0] x);
    logic [24:0] y;
    y = {x, 8'b0} - {8'b0, x};
    return y[23:16];
  endfunction

endpackage
`default_nettype wire

// ===== src/rbl_if.sv =====
// Valid/ready channel interfaces for pixels in and LED bytes out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rbl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rbl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  modport source (output valid, first_byte, second_byte, third_byte, input ready);
  modport sink   (input valid, first_byte, second_byte, third_byte, output ready);
endinterface
`default_nettype wire

// ===== src/rbl_front.sv =====
// First stage: max/min, sector base, value clamp and first divider step.
// Depends on rbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbl_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         valid_in,
  input  wire logic [7:0]   red,
  input  wire logic [7:0]   green,
  input  wire logic [7:0]   blue,
  input  wire logic [7:0]   max_level,
  output rbl_pkg::div_t     d_r,
  output logic              valid_r
);
  import rbl_pkg::*;

  logic [7:0] mx, mn, d, a, c, absn, v8;
  logic [1:0] which;
  div_t       d_nxt;

  always_comb begin
    mx = red; mn = red; which = 2'd0;
    if (green > mx) begin mx = green; which = 2'd1; end
    if (green < mn) mn = green;
    if (blue > mx) begin mx = blue; which = 2'd2; end
    if (blue < mn) mn = blue;
    d = mx - mn;
    case (which)
      2'd1:    begin a = blue; c = red;   d_nxt.base = 3'd2; end
      2'd2:    begin a = red;  c = green; d_nxt.base = 3'd4; end
      default: begin a = green; c = blue; d_nxt.base = 3'd0; end
    endcase
    d_nxt.neg  = a < c;
    absn       = d_nxt.neg ? (c - a) : (a - c);
    d_nxt.grey = (d == 8'd0);
    // leading quotient bit: numerator never exceeds divisor
    d_nxt.den_h = d;
    d_nxt.q_h   = {16'b0, absn == d};
    d_nxt.rem_h = (absn == d) ? 8'd0 : absn;
    d_nxt.den_s = mx;
    d_nxt.q_s   = {16'b0, d == mx};
    d_nxt.rem_s = (d == mx) ? 8'd0 : d;
    v8 = (mx > max_level) ? max_level : mx;
    // v8 * 65536 / 255 = v8 * 257, plus one at full scale
    d_nxt.v = {1'b0, v8, v8} + {16'b0, v8 == 8'hFF};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/rbl_div_stage.sv =====
// One pipeline stage of the hue and saturation dividers, STEPS bits each.
// Depends on rbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbl_div_stage #(
  parameter int STEPS = rbl_pkg::DIV_STEPS_A
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         valid_in,
  input  wire rbl_pkg::div_t d_in,
  output rbl_pkg::div_t     d_r,
  output logic              valid_r
);
  import rbl_pkg::*;

  div_t  d_nxt;
  step_t sh, ss;

  always_comb begin
    d_nxt = d_in;
    for (int i = 0; i < STEPS; i++) begin
      sh = div_step(d_nxt.rem_h, d_nxt.q_h, d_nxt.den_h);
      ss = div_step(d_nxt.rem_s, d_nxt.q_s, d_nxt.den_s);
      d_nxt.rem_h = sh.rem;
      d_nxt.q_h   = sh.q;
      d_nxt.rem_s = ss.rem;
      d_nxt.q_s   = ss.q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/rbl_back.sv =====
// Back end: hue assembly, p/q/t products, sector select, byte scaling and
// LED channel reorder over four register stages. Depends on rbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbl_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire rbl_pkg::div_t d_in,
  input  wire logic [2:0]    channel_order,
  output logic [7:0]         byte0_r,
  output logic [7:0]         byte1_r,
  output logic [7:0]         byte2_r,
  output logic               valid_r
);
  import rbl_pkg::*;

  // hue stage
  logic [18:0] hb, h_nxt;
  logic [2:0]  sec5_r;
  logic [15:0] f5_r;
  logic [16:0] s5_r, v5_r;
  logic        vld5_r;
  // s*f stage
  logic [32:0] sf_full;
  logic [33:0] snf_full;
  logic [16:0] sf6_r, snf6_r, s6_r, v6_r;
  logic [2:0]  sec6_r;
  logic        vld6_r;
  // p/q/t stage
  logic [33:0] p_full, q_full, t_full;
  logic [16:0] p7_r, q7_r, t7_r, v7_r;
  logic [2:0]  sec7_r;
  logic        vld7_r;
  // select stage
  logic [16:0] cr, cg, cb;
  logic [7:0]  br, bg, bb, b0_nxt, b1_nxt, b2_nxt;

  always_comb begin
    hb = {d_in.base, 16'b0};
    if (!d_in.neg) begin
      h_nxt = hb + {2'b0, d_in.q_h};
    end else if (d_in.base == 3'd0) begin
      h_nxt = H_TURN - {2'b0, d_in.q_h};  // wrap negative hue
    end else begin
      h_nxt = hb - {2'b0, d_in.q_h};
    end
  end

  assign sf_full  = {16'b0, s5_r} * {17'b0, f5_r};
  assign snf_full = {17'b0, s5_r} * {17'b0, ONE_Q16 - {1'b0, f5_r}};

  assign p_full = {17'b0, v6_r} * {17'b0, ONE_Q16 - s6_r};
  assign q_full = {17'b0, v6_r} * {17'b0, ONE_Q16 - sf6_r};
  assign t_full = {17'b0, v6_r} * {17'b0, ONE_Q16 - snf6_r};

  always_comb begin
    case (sec7_r)
      3'd0:    begin cr = v7_r; cg = t7_r; cb = p7_r; end
      3'd1:    begin cr = q7_r; cg = v7_r; cb = p7_r; end
      3'd2:    begin cr = p7_r; cg = v7_r; cb = t7_r; end
      3'd3:    begin cr = p7_r; cg = q7_r; cb = v7_r; end
      3'd4:    begin cr = t7_r; cg = p7_r; cb = v7_r; end
      default: begin cr = v7_r; cg = p7_r; cb = q7_r; end
    endcase
    br = scale_byte(cr);
    bg = scale_byte(cg);
    bb = scale_byte(cb);
    case (channel_order)
      ORD_RBG: begin b0_nxt = br; b1_nxt = bb; b2_nxt = bg; end
      ORD_GBR: begin b0_nxt = bg; b1_nxt = bb; b2_nxt = br; end
      ORD_GRB: begin b0_nxt = bg; b1_nxt = br; b2_nxt = bb; end
      ORD_BRG: begin b0_nxt = bb; b1_nxt = br; b2_nxt = bg; end
      ORD_BGR: begin b0_nxt = bb; b1_nxt = bg; b2_nxt = br; end
      default: begin b0_nxt = br; b1_nxt = bg; b2_nxt = bb; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r  <= 1'b0;
      vld6_r  <= 1'b0;
      vld7_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      vld5_r  <= valid_in;
      vld6_r  <= vld5_r;
      vld7_r  <= vld6_r;
      valid_r <= vld7_r;
    end
    if (en) begin
      // grey pixel: hue and saturation are zero
      sec5_r <= d_in.grey ? 3'd0 : h_nxt[18:16];
      f5_r   <= d_in.grey ? 16'd0 : h_nxt[15:0];
      s5_r   <= d_in.grey ? 17'd0 : d_in.q_s;
      v5_r   <= d_in.v;
      sf6_r  <= sf_full[32:16];
      snf6_r <= snf_full[32:16];
      s6_r   <= s5_r;
      v6_r   <= v5_r;
      sec6_r <= sec5_r;
      p7_r   <= p_full[32:16];
      q7_r   <= q_full[32:16];
      t7_r   <= t_full[32:16];
      v7_r   <= v6_r;
      sec7_r <= sec6_r;
      byte0_r <= b0_nxt;
      byte1_r <= b1_nxt;
      byte2_r <= b2_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/rgb_brightness_limit_reorder_top.sv =====
// Top level of the RGB brightness limiter with LED channel reorder.
// Depends on rbl_pkg, rbl_if, rbl_front, rbl_div_stage, rbl_back.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        red_in, green_in, blue_in (8b each)
//   out_ch   out  valid/ready        first_byte, second_byte, third_byte
//   cfg_*    in   cfg_we, cfg_idx    cfg_wdata (8b): max_level, channel_order
//
// Eight register stages: front, three divider stages (hue fraction and
// saturation, long division), hue assembly, s*f products, p/q/t products,
// select and reorder into the output register. One item per cycle unless
// the output stalls. The whole pipe advances together whenever the output
// register is empty or taken, so a stall freezes every stage. Synchronous
// reset clears valid bits and restores max_level 255 and rgb order.
`timescale 1ns / 1ps
`default_nettype none
module rgb_brightness_limit_reorder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rbl_in_if.sink          in_ch,
  rbl_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_idx,
  input  wire logic [7:0] cfg_wdata
);
  import rbl_pkg::*;

  logic       en;
  logic [7:0] max_level_r;
  logic [2:0] channel_order_r;
  div_t       d1, d2, d3, d4;
  logic       v1, v2, v3, v4;

  assign en          = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r     <= 8'hFF;
      channel_order_r <= ORD_RGB;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAX_LEVEL:     max_level_r     <= cfg_wdata;
        REG_CHANNEL_ORDER: channel_order_r <= cfg_wdata[2:0];
        default:           ;
      endcase
    end
  end

  rbl_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(in_ch.valid),
    .red(in_ch.red_in), .green(in_ch.green_in), .blue(in_ch.blue_in),
    .max_level(max_level_r), .d_r(d1), .valid_r(v1)
  );

  rbl_div_stage #(.STEPS(DIV_STEPS_A)) u_div_a (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v1), .d_in(d1),
    .d_r(d2), .valid_r(v2)
  );

  rbl_div_stage #(.STEPS(DIV_STEPS_B)) u_div_b (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v2), .d_in(d2),
    .d_r(d3), .valid_r(v3)
  );

  rbl_div_stage #(.STEPS(DIV_STEPS_C)) u_div_c (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v3), .d_in(d3),
    .d_r(d4), .valid_r(v4)
  );

  rbl_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v4), .d_in(d4),
    .channel_order(channel_order_r),
    .byte0_r(out_ch.first_byte), .byte1_r(out_ch.second_byte),
    .byte2_r(out_ch.third_byte), .valid_r(out_ch.valid)
  );
endmodule
`default_nettype wire

// ===== src/rbl_checker.sv =====
// Port-level checks for the brightness limiter, bound to the top level.
// Depends on rgb_brightness_limit_reorder_top.
`timescale 1ns / 1ps
`default_nettype none
module rbl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] first_byte,
  input wire logic [7:0] second_byte,
  input wire logic [7:0] third_byte
);
  // no items survive reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // pipe accepts exactly when the output register can move
  a_ready_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("input ready does not follow output side");

  // a stalled item stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(first_byte)
      && $stable(second_byte) && $stable(third_byte))
    else $error("stalled item changed");

  // in_valid, in_ready and out_valid are always known, and so is an offered item
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, in_ready, out_valid})
      && (!out_valid || !$isunknown({first_byte, second_byte, third_byte})))
    else $error("unknown handshake or output item");
endmodule

bind rgb_brightness_limit_reorder_top rbl_checker u_rbl_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .first_byte(out_ch.first_byte), .second_byte(out_ch.second_byte),
  .third_byte(out_ch.third_byte)
);
`default_nettype wire
